@@ rtl/core/dstq_pkg.sv @@
// ----------------------------------------------------------------------------
// dstq_pkg
// Shared types and codes for the deadline sorted timer queue.
// ----------------------------------------------------------------------------
package dstq_pkg;

    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int TIME_W    = 32;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 16;
    localparam int REM_W     = 31;
    localparam int MAX_FIRE  = 16;
    localparam int FIRE_W    = 5;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [KIND_W-1:0] {
        KIND_SCHEDULE = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_FIND     = 2'd2,
        KIND_REMOVE   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_SCHEDULED = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FIRED     = 3'd4
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0]    deadline;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/core/deadline_sorted_timer_queue_top.sv @@
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue_top
// Deadline-sorted queue of deferred calls held in a circular RAM buffer.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          tuser        tdata (low bit up)
// s_*       in   s_tvalid/s_tready  kind[1:0]    delay, key, payload
// m_*       out  m_tvalid/m_tready  status[2:0]  remaining, fired_key, fired_payload
//
// One command at a time; each entry visited takes a RAM read step, then a
// check/write step. A remove's shift carries the walk on past the hit.
// Tick pops from the head pointer without moving entries.
// Reset clears time, count and head; the RAM needs no clearing.
// A stalled m_tready holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
module deadline_sorted_timer_queue_top
    import dstq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // delay[31:0], key[63:32], payload[79:64]
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // remaining[30:0], fired_key[62:31],
                                             // fired_payload[78:63], zero[79]
    output logic [STATUS_W-1:0]   m_tuser,   // status[2:0]
    output logic                  m_tlast
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CHK, S_FIRE_RD, S_FIRE_CHK,
        S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_CHK, S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [FIRE_W-1:0]    n_reg, n_next;
    kind_t                kind_reg, kind_next;
    entry_t               new_reg, new_next;
    entry_t               held_reg, held_next;
    logic                 held_valid_reg, held_valid_next;
    status_t              res_status_reg, res_status_next;
    logic [REM_W-1:0]     res_rem_reg, res_rem_next;
    logic [KEY_W-1:0]     res_key_reg, res_key_next;
    logic [PAYLOAD_W-1:0] res_pay_reg, res_pay_next;
    logic                 res_last_reg, res_last_next;
    logic                 ret_fire_reg, ret_fire_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;
    logic [IDX_W-1:0]     rd_addr;
    entry_t               rd_data;

    logic [TIME_W-1:0]    s_delay;
    logic [TIME_W-1:0]    delay_eff;
    logic [TIME_W:0]      dl_sum;
    logic [TIME_W-1:0]    rem_diff;

    // logical position -> physical RAM address relative to the head
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] l);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(l);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    dstq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign s_delay   = s_tdata[TIME_W-1:0];
    assign delay_eff = (s_delay[TIME_W-1] || s_delay == '0) ? TIME_W'(1) : s_delay;
    assign dl_sum    = {1'b0, now_reg} + {1'b0, delay_eff};
    assign rem_diff  = rd_data.deadline - now_reg;

    always_comb
    begin
        case (state_reg)
            S_INS_RD, S_INS_CHK:
                rd_addr = phys(head_reg, (idx_reg == '0) ? '0 : idx_reg - CNT_W'(1));
            S_FIRE_RD, S_FIRE_CHK:
                rd_addr = head_reg;
            default:
                rd_addr = phys(head_reg, idx_reg);
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        kind_next       = kind_reg;
        new_next        = new_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        res_status_next = res_status_reg;
        res_rem_next    = res_rem_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        res_last_next   = res_last_reg;
        ret_fire_next   = ret_fire_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        wr_en           = 1'b0;
        wr_addr         = phys(head_reg, idx_reg);
        wr_data         = new_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next        = kind_t'(s_tuser);
                    new_next.key     = s_tdata[TIME_W +: KEY_W];
                    new_next.payload = s_tdata[TIME_W+KEY_W +: PAYLOAD_W];
                    idx_next         = '0;
                    res_rem_next     = '0;
                    res_key_next     = '0;
                    res_pay_next     = '0;
                    res_last_next    = 1'b1;
                    ret_fire_next    = 1'b0;
                    case (kind_t'(s_tuser))
                        KIND_SCHEDULE:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                res_status_next = STAT_FULL;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                new_next.deadline = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
                                idx_next          = count_reg;
                                state_next        = S_INS_RD;
                            end
                        end
                        KIND_TICK:
                        begin
                            if (now_reg != '1)
                            begin
                                now_next = now_reg + TIME_W'(1);
                            end
                            n_next          = '0;
                            held_valid_next = 1'b0;
                            state_next      = S_FIRE_RD;
                        end
                        default:
                        begin
                            state_next = S_SCAN_RD;
                        end
                    endcase
                end
            end

            // walk down from the tail, moving later-or-equal deadlines up one
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = head_reg;
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = STAT_SCHEDULED;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_INS_CHK;
                end
            end

            S_INS_CHK:
            begin
                wr_en = 1'b1;
                if (rd_data.deadline >= new_reg.deadline)
                begin
                    wr_data    = rd_data;
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = STAT_SCHEDULED;
                    state_next      = S_EMIT;
                end
            end

            // the fired entry is held back one step so the final one gets tlast
            S_FIRE_RD:
            begin
                if (count_reg == '0 || n_reg == FIRE_W'(MAX_FIRE))
                begin
                    if (held_valid_reg)
                    begin
                        res_status_next = STAT_FIRED;
                        res_key_next    = held_reg.key;
                        res_pay_next    = held_reg.payload;
                        res_last_next   = 1'b1;
                        ret_fire_next   = 1'b0;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_FIRE_CHK;
                end
            end

            S_FIRE_CHK:
            begin
                if (rd_data.deadline <= now_reg)
                begin
                    held_next       = rd_data;
                    held_valid_next = 1'b1;
                    head_next       = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                    count_next      = count_reg - CNT_W'(1);
                    n_next          = n_reg + FIRE_W'(1);
                    if (held_valid_reg)
                    begin
                        res_status_next = STAT_FIRED;
                        res_key_next    = held_reg.key;
                        res_pay_next    = held_reg.payload;
                        res_last_next   = 1'b0;
                        ret_fire_next   = 1'b1;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_FIRE_RD;
                    end
                end
                else if (held_valid_reg)
                begin
                    res_status_next = STAT_FIRED;
                    res_key_next    = held_reg.key;
                    res_pay_next    = held_reg.payload;
                    res_last_next   = 1'b1;
                    ret_fire_next   = 1'b0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                idx_next = idx_reg + CNT_W'(1);
                if (rd_data.key == new_reg.key)
                begin
                    res_status_next = STAT_FOUND;
                    res_key_next    = rd_data.key;
                    res_pay_next    = rd_data.payload;
                    if (rd_data.deadline <= now_reg)
                    begin
                        res_rem_next = '0;
                    end
                    else if (rem_diff[TIME_W-1])
                    begin
                        res_rem_next = '1;
                    end
                    else
                    begin
                        res_rem_next = rem_diff[REM_W-1:0];
                    end
                    state_next = (kind_reg == KIND_REMOVE) ? S_SHIFT_RD : S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end

            // close the gap left by a removed entry
            S_SHIFT_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SHIFT_CHK;
                end
            end

            S_SHIFT_CHK:
            begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, idx_reg - CNT_W'(1));
                wr_data    = rd_data;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_SHIFT_RD;
            end

            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_pay_reg, res_key_reg, res_rem_reg};
                    m_tuser_next  = res_status_reg;
                    m_tlast_next  = res_last_reg;
                    state_next    = ret_fire_reg ? S_FIRE_RD : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            held_valid_reg <= 1'b0;
            ret_fire_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            held_valid_reg <= held_valid_next;
            ret_fire_reg   <= ret_fire_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        new_reg        <= new_next;
        held_reg       <= held_next;
        res_status_reg <= res_status_next;
        res_rem_reg    <= res_rem_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        res_last_reg   <= res_last_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

endmodule

@@ rtl/core/dstq_ram.sv @@
// ----------------------------------------------------------------------------
// dstq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dstq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/dstq_checker.sv @@
// ----------------------------------------------------------------------------
// dstq_checker
// Port-level checks for the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module dstq_checker
    import dstq_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [KIND_W-1:0]     s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]   m_tuser,
    input logic                  m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only fired results may come without tlast
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_FIRED) |-> m_tlast)
        else $error("non-fired result without tlast");

    a_fired_rem: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_FIRED) |-> m_tdata[REM_W-1:0] == '0)
        else $error("fired result with remaining time");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_NOT_FOUND || m_tuser == STAT_FULL ||
                     m_tuser == STAT_SCHEDULED) |-> m_tdata == '0)
        else $error("status without entry carries data");

endmodule

bind deadline_sorted_timer_queue_top dstq_checker u_dstq_checker (.*);

@@ bench/deadline_sorted_timer_queue_top_test.sv @@
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue_top_test
// Drives schedule, tick, find and remove commands into the timer queue, keeps
// a shadow sorted queue to predict every result, and compares each transfer
// on the result stream field by field with random gaps on both sides.
// ----------------------------------------------------------------------------
module deadline_sorted_timer_queue_top_test;
    import dstq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        status_t              status;
        logic [REM_W-1:0]     remaining;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } timer_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    // shadow queue state
    logic [TIME_W-1:0]    shadow_now;
    entry_t               shadow_q[$];
    timer_result_t        pending_results[$];
    logic [KEY_W-1:0]     used_keys[$];
    int                   errors;
    int                   idle_cycles;
    bit                   rx_stall_enable;

    deadline_sorted_timer_queue_top #(.QUEUE_DEPTH(DEPTH)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void push_result(status_t st, logic [REM_W-1:0] rem,
                                        logic [KEY_W-1:0] k,
                                        logic [PAYLOAD_W-1:0] p, logic l);
        timer_result_t r;
        r.status    = st;
        r.remaining = rem;
        r.key       = k;
        r.payload   = p;
        r.last      = l;
        pending_results.push_back(r);
    endfunction

    // Updates the shadow queue for one command and queues its results.
    function automatic void predict_command(kind_t kind, logic [31:0] delay,
                                            logic [KEY_W-1:0] k,
                                            logic [PAYLOAD_W-1:0] p);
        logic [32:0]       dl;
        logic [TIME_W-1:0] rem_gap;
        entry_t            e;
        int                pos;
        int                n;
        int                hit;
        case (kind)
            KIND_SCHEDULE:
            begin
                if (shadow_q.size() >= DEPTH)
                begin
                    push_result(STAT_FULL, '0, '0, '0, 1'b1);
                end
                else
                begin
                    if (delay[31] || delay == 0)
                        delay = 32'd1;
                    dl = {1'b0, shadow_now} + {1'b0, delay};
                    if (dl[32])
                        dl = {1'b0, 32'hFFFF_FFFF};
                    e.deadline = dl[31:0];
                    e.key      = k;
                    e.payload  = p;
                    pos = 0;
                    while (pos < shadow_q.size() && shadow_q[pos].deadline < e.deadline)
                        pos++;
                    shadow_q.insert(pos, e);
                    push_result(STAT_SCHEDULED, '0, '0, '0, 1'b1);
                end
            end
            KIND_TICK:
            begin
                if (shadow_now != 32'hFFFF_FFFF)
                    shadow_now++;
                n = 0;
                while (shadow_q.size() > 0 && shadow_q[0].deadline <= shadow_now
                       && n < MAX_FIRE)
                begin
                    push_result(STAT_FIRED, '0, shadow_q[0].key, shadow_q[0].payload,
                                1'b0);
                    void'(shadow_q.pop_front());
                    n++;
                end
                if (n > 0)
                    pending_results[pending_results.size()-1].last = 1'b1;
            end
            default:
            begin
                hit = -1;
                for (int i = 0; i < shadow_q.size(); i++)
                begin
                    if (hit < 0 && shadow_q[i].key == k)
                        hit = i;
                end
                if (hit < 0)
                begin
                    push_result(STAT_NOT_FOUND, '0, '0, '0, 1'b1);
                end
                else
                begin
                    rem_gap = (shadow_q[hit].deadline > shadow_now) ?
                              shadow_q[hit].deadline - shadow_now : '0;
                    if (rem_gap[31])
                        rem_gap = 32'h7FFF_FFFF;
                    push_result(STAT_FOUND, rem_gap[REM_W-1:0], shadow_q[hit].key,
                                shadow_q[hit].payload, 1'b1);
                    if (kind == KIND_REMOVE)
                        shadow_q.delete(hit);
                end
            end
        endcase
    endfunction

    task automatic send_command(kind_t kind, logic [31:0] delay, logic [KEY_W-1:0] k,
                                logic [PAYLOAD_W-1:0] p);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {p, k, delay};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_command(kind, delay, k, p);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        timer_result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d data=%h last=%b",
                         $time, m_tuser, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (m_tuser !== exp.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp.status,
                             m_tuser);
                    errors++;
                end
                if (m_tdata[30:0] !== exp.remaining)
                begin
                    $display("%0t: remaining expected %h actual %h", $time,
                             exp.remaining, m_tdata[30:0]);
                    errors++;
                end
                if (m_tdata[62:31] !== exp.key)
                begin
                    $display("%0t: key expected %h actual %h", $time, exp.key,
                             m_tdata[62:31]);
                    errors++;
                end
                if (m_tdata[78:63] !== exp.payload)
                begin
                    $display("%0t: payload expected %h actual %h", $time,
                             exp.payload, m_tdata[78:63]);
                    errors++;
                end
                if (m_tlast !== exp.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, exp.last,
                             m_tlast);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls: random length per transfer, disabled in some stretches
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_stall_enable ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size()-1)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'h8000_0000 | $urandom;
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return $urandom;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    task automatic schedule_random();
        logic [KEY_W-1:0] k;
        k = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 15);
        used_keys.push_back(k);
        send_command(KIND_SCHEDULE, pick_delay(), k, PAYLOAD_W'($urandom));
    endtask

    task automatic test_directed();
        // fill to the limit and past it, equal deadlines, extreme field values
        send_command(KIND_FIND, '0, 32'hFFFF_FFFF, '0);
        send_command(KIND_REMOVE, '0, '0, '0);
        send_command(KIND_SCHEDULE, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        send_command(KIND_SCHEDULE, 32'h8000_0000, 32'h0000_0000, 16'h0000);
        send_command(KIND_SCHEDULE, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 16'h5A5A);
        send_command(KIND_SCHEDULE, 32'h7FFF_FFFF, 32'h0000_0001, 16'h1234);
        send_command(KIND_SCHEDULE, 32'd3, 32'h0000_0002, 16'h8001);
        send_command(KIND_FIND, '0, 32'h0000_0001, '0);
        send_command(KIND_FIND, '0, 32'h0000_0002, '0);
        for (int i = 0; i < 12; i++)
            send_command(KIND_SCHEDULE, 32'd2, 32'h100 + i, 16'(i));
        send_command(KIND_SCHEDULE, 32'd5, 32'h7777, 16'h7777);
        send_command(KIND_REMOVE, '0, 32'h0000_0002, '0);
        send_command(KIND_TICK, $urandom, $urandom, PAYLOAD_W'($urandom));
        send_command(KIND_TICK, $urandom, $urandom, PAYLOAD_W'($urandom));
        send_command(KIND_TICK, $urandom, $urandom, PAYLOAD_W'($urandom));
        send_command(KIND_REMOVE, '0, 32'hA5A5_5A5A, '0);
    endtask

    // Fill the queue with one due time so a single tick fires all of those entries
    task automatic test_burst_fire();
        for (int i = 0; i < DEPTH + 2; i++)
            send_command(KIND_SCHEDULE, 32'd1, $urandom, PAYLOAD_W'($urandom));
        send_command(KIND_TICK, '0, '0, '0);
        send_command(KIND_TICK, '0, '0, '0);
    endtask

    task automatic test_random_mix(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 50)
                rx_stall_enable = ~rx_stall_enable;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                schedule_random();
            else if (pick < 7)
                send_command(KIND_TICK, $urandom, $urandom, PAYLOAD_W'($urandom));
            else if (pick < 8)
                send_command(KIND_FIND, $urandom, pick_key(), PAYLOAD_W'($urandom));
            else
                send_command(KIND_REMOVE, $urandom, pick_key(), PAYLOAD_W'($urandom));
        end
    endtask

    initial
    begin
        int drain;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        shadow_now = '0;
        errors = 0;
        idle_cycles = 0;
        rx_stall_enable = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_burst_fire();
        test_random_mix(400);
        s_tvalid <= 1'b0;
        drain = 0;
        while (pending_results.size() > 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dstq_pkg.sv
rtl/core/dstq_ram.sv
rtl/core/deadline_sorted_timer_queue_top.sv
rtl/core/dstq_checker.sv
bench/deadline_sorted_timer_queue_top_test.sv
